// ----- src/oale_pkg.sv -----
// Shared types and codes for the ordered array list engine.
// No dependencies.
package oale_pkg;

	typedef logic [2:0]         func_t;
	typedef logic [1:0]         status_t;
	typedef logic signed [11:0] index_t;
	typedef logic signed [31:0] word_t;

	localparam func_t FN_APPEND     = 3'd0;
	localparam func_t FN_FIND       = 3'd1;
	localparam func_t FN_REMOVE_AT  = 3'd2;
	localparam func_t FN_REMOVE_ALL = 3'd3;
	localparam func_t FN_INSERT_AT  = 3'd4;
	localparam func_t FN_READ_AT    = 3'd5;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_RANGE   = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;
	localparam status_t STAT_IGNORED = 2'd3;

endpackage

// ----- src/oale_mem.sv -----
// Word store: one write port, one read port, registered read data.
// Depends on oale_pkg.
module oale_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  oale_pkg::word_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output oale_pkg::word_t rdata
);
	import oale_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/oale_ctrl.sv -----
// Sequencer: decodes requests, walks the store one access per cycle,
// shifts or compacts words and forms the result. Depends on oale_pkg.
module oale_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int AW       = 10,
	parameter int CW       = 11,
	parameter int PW       = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  oale_pkg::func_t       func,
	input  oale_pkg::index_t      index,
	input  oale_pkg::word_t       value,
	output logic                  done,
	output oale_pkg::status_t     status,
	output logic signed [PW-1:0]  position,
	output oale_pkg::word_t       element,
	output logic [CW-1:0]         count,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output oale_pkg::word_t       mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  oale_pkg::word_t       mem_rdata
);
	import oale_pkg::*;

	localparam int XW = (CW > 11) ? CW : 11;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;

	logic [1:0]    st_q, st_d;
	func_t         op_q, op_d;
	word_t         val_q, val_d;
	logic [AW-1:0] rp_q, rp_d;
	logic [AW-1:0] last_q, last_d;
	logic          up_q, up_d;
	logic          issue_q, issue_d;
	logic          v_s1, v_d;
	logic [AW-1:0] addr_s1, addr_d;
	logic [CW-1:0] wp_q, wp_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          done_q;
	status_t       status_q;
	logic [PW-1:0] pos_q;
	word_t         elem_q;

	logic          fin;
	status_t       fin_status;
	logic [PW-1:0] fin_pos;
	word_t         fin_elem;

	logic          idx_neg, idx_lt, full, keep;
	logic [AW-1:0] idx_a, cnt_m1;

	assign idx_neg = index[11];
	assign idx_lt  = XW'(index[10:0]) < XW'(cnt_q);
	assign full    = cnt_q == CW'(CAPACITY);
	assign idx_a   = AW'(index[10:0]);
	assign cnt_m1  = AW'(cnt_q - 1'b1);
	assign keep    = mem_rdata != val_q;

	always_comb begin
		st_d       = st_q;
		op_d       = op_q;
		val_d      = val_q;
		rp_d       = rp_q;
		last_d     = last_q;
		up_d       = up_q;
		issue_d    = issue_q;
		v_d        = 1'b0;
		addr_d     = addr_s1;
		wp_d       = wp_q;
		cnt_d      = cnt_q;
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_pos    = '1;
		fin_elem   = '0;
		mem_we     = 1'b0;
		mem_waddr  = AW'(cnt_q);
		mem_wdata  = value;
		mem_re     = 1'b0;
		mem_raddr  = rp_q;
		case (st_q)
			S_IDLE: begin
				if (start) begin
					op_d  = func;
					val_d = value;
					case (func)
						FN_APPEND: begin
							fin = 1'b1;
							if (full) begin
								fin_status = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						FN_FIND, FN_REMOVE_ALL: begin
							if (cnt_q == '0) begin
								fin = 1'b1;
							end else begin
								st_d    = S_RUN;
								issue_d = 1'b1;
								rp_d    = '0;
								last_d  = cnt_m1;
								up_d    = 1'b1;
								wp_d    = '0;
							end
						end
						FN_REMOVE_AT: begin
							if (idx_neg || !idx_lt) begin
								fin        = 1'b1;
								fin_status = STAT_RANGE;
							end else if (idx_a == cnt_m1) begin
								fin   = 1'b1;
								cnt_d = cnt_q - 1'b1;
							end else begin
								st_d    = S_RUN;
								issue_d = 1'b1;
								rp_d    = idx_a + 1'b1;
								last_d  = cnt_m1;
								up_d    = 1'b1;
							end
						end
						FN_INSERT_AT: begin
							if (idx_neg) begin
								fin        = 1'b1;
								fin_status = STAT_IGNORED;
							end else if (full) begin
								fin        = 1'b1;
								fin_status = STAT_FULL;
							end else if (!idx_lt) begin
								fin    = 1'b1;
								mem_we = 1'b1;
								cnt_d  = cnt_q + 1'b1;
							end else begin
								st_d    = S_RUN;
								issue_d = 1'b1;
								rp_d    = cnt_m1;
								last_d  = idx_a;
								up_d    = 1'b0;
							end
						end
						FN_READ_AT: begin
							if (idx_neg || !idx_lt) begin
								fin        = 1'b1;
								fin_status = STAT_RANGE;
							end else begin
								st_d    = S_RUN;
								issue_d = 1'b1;
								rp_d    = idx_a;
								last_d  = idx_a;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_RUN: begin
				if (issue_q) begin
					mem_re = 1'b1;
					v_d    = 1'b1;
					addr_d = rp_q;
					if (rp_q == last_q) begin
						issue_d = 1'b0;
					end else begin
						rp_d = up_q ? rp_q + 1'b1 : rp_q - 1'b1;
					end
				end
				if (v_s1) begin
					mem_wdata = mem_rdata;
					case (op_q)
						FN_FIND: begin
							if (!keep) begin
								fin     = 1'b1;
								fin_pos = PW'(addr_s1);
							end else if (addr_s1 == last_q) begin
								fin = 1'b1;
							end
						end
						FN_REMOVE_AT: begin
							mem_we    = 1'b1;
							mem_waddr = addr_s1 - 1'b1;
							if (addr_s1 == last_q) begin
								fin   = 1'b1;
								cnt_d = cnt_q - 1'b1;
							end
						end
						FN_REMOVE_ALL: begin
							mem_we    = keep;
							mem_waddr = AW'(wp_q);
							wp_d      = wp_q + CW'(keep);
							if (addr_s1 == last_q) begin
								fin   = 1'b1;
								cnt_d = wp_q + CW'(keep);
							end
						end
						FN_INSERT_AT: begin
							mem_we    = 1'b1;
							mem_waddr = addr_s1 + 1'b1;
							if (addr_s1 == last_q) begin
								st_d = S_PUT;
							end
						end
						default: begin
							fin      = 1'b1;
							fin_elem = mem_rdata;
						end
					endcase
					if (fin) begin
						st_d    = S_IDLE;
						issue_d = 1'b0;
						v_d     = 1'b0;
					end
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = last_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + 1'b1;
				fin       = 1'b1;
				st_d      = S_IDLE;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			issue_q <= issue_d;
			v_s1    <= v_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		val_q   <= val_d;
		rp_q    <= rp_d;
		last_q  <= last_d;
		up_q    <= up_d;
		addr_s1 <= addr_d;
		wp_q    <= wp_d;
		if (fin) begin
			status_q <= fin_status;
			pos_q    <= fin_pos;
			elem_q   <= fin_elem;
		end
	end

	assign busy     = st_q != S_IDLE;
	assign done     = done_q;
	assign status   = status_q;
	assign position = pos_q;
	assign element  = elem_q;
	assign count    = cnt_q;

endmodule

// ----- src/ordered_array_list_engine.sv -----
// Top level of the ordered array list engine: sequencer plus word store.
// Depends on oale_pkg, oale_ctrl, oale_mem.
//
// Usage: drive func, index and value with start; the request transfers at a
// rising edge where start is high and busy is low. Exactly one result comes
// back per request: done is high for one cycle with status, position,
// element and count valid in that cycle. The receiver cannot stall.
// Requests that finish without a walk of the store: append, insert at the
// end, rejected requests, remove of the last word, find or remove all on an
// empty list, unused codes. Other requests walk the store: find stops at
// the first hit, remove at shifts the tail down, remove all compacts it,
// insert at p < count shifts the tail up and then writes at p, read at
// reads one word.
// busy drops in the done cycle, so the next request may transfer at the
// edge that ends it. The walk costs one store access per cycle through the
// single read port and single write port of the store.
// Reset empties the list at once; store contents are not cleared.
module ordered_array_list_engine #(
	parameter int CAPACITY = 1024
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  oale_pkg::func_t                            func,
	input  oale_pkg::index_t                           index,
	input  oale_pkg::word_t                            value,
	output logic                                       done,
	output oale_pkg::status_t                          status,
	output logic signed [$clog2(CAPACITY):0]           position,
	output oale_pkg::word_t                            element,
	output logic [$clog2(CAPACITY+1)-1:0]              count
);
	import oale_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = AW + 1;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	word_t         mem_wdata, mem_rdata;

	oale_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW),
		.PW       (PW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.index     (index),
		.value     (value),
		.done      (done),
		.status    (status),
		.position  (position),
		.element   (element),
		.count     (count),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	oale_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
